// ===== sv/assert_macros.svh =====
// assertion helpers, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/tga_pkg.sv =====
`default_nettype none
package tga_pkg;
   localparam logic [15:0] MIN_RUN_WIDTH = 16'd3;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_SPAN   = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   localparam logic [1:0] ERR_TYPE     = 2'd0;
   localparam logic [1:0] ERR_DEPTH    = 2'd1;
   localparam logic [1:0] ERR_TRUNC    = 2'd2;
   localparam logic [1:0] ERR_NARROW   = 2'd3;

   localparam logic [7:0] TYPE_RAW = 8'd2;
   localparam logic [7:0] TYPE_RLE = 8'd10;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;

   typedef enum logic [2:0] {
      PH_IDLE, PH_HEADER, PH_SKIP, PH_PACKET, PH_PIXEL
   } phase_type;

   typedef enum logic {
      CS_WAIT, CS_EMIT
   } ctl_state_type;

   typedef struct packed {
      logic take_byte;
      logic emit_step;
   } cmd_type;

   typedef struct packed {
      logic will_emit;
      logic out_free;
      logic last_now;
      logic pending;
   } sts_type;
endpackage
`default_nettype wire

// ===== sv/tga_ctrl.sv =====
`default_nettype none
module tga_ctrl import tga_pkg::*; (
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         CS_WAIT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_byte = 1'b1;
               if (sts.will_emit) state_in = CS_EMIT;
            end
         end
         CS_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_step = 1'b1;
               if (sts.last_now) state_in = CS_WAIT;
            end
         end
         default: state_in = CS_WAIT;
      endcase
   end
endmodule
`default_nettype wire

// ===== sv/tga_dpath.sv =====
`default_nettype none
module tga_dpath import tga_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_first_byte,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_end_of_stream,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_fault,
   output logic [15:0] rsp_row,
   output logic [15:0] rsp_column,
   output logic [7:0]  rsp_span_length,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic        rsp_last_result
);
   localparam logic [4:0] HB_ID_LEN  = 5'd0;
   localparam logic [4:0] HB_MAP     = 5'd1;
   localparam logic [4:0] HB_TYPE    = 5'd2;
   localparam logic [4:0] HB_MLEN_LO = 5'd5;
   localparam logic [4:0] HB_MLEN_HI = 5'd6;
   localparam logic [4:0] HB_MBITS   = 5'd7;
   localparam logic [4:0] HB_W_LO    = 5'd12;
   localparam logic [4:0] HB_W_HI    = 5'd13;
   localparam logic [4:0] HB_H_LO    = 5'd14;
   localparam logic [4:0] HB_H_HI    = 5'd15;
   localparam logic [4:0] HB_DEPTH   = 5'd16;
   localparam logic [4:0] HB_DESC    = 5'd17;

   phase_type   phase_ff, phase_in;
   logic [4:0]  hidx_ff, hidx_in;
   logic [7:0]  id_len_ff, id_len_in;
   logic        is_rle_ff, is_rle_in;
   logic        map_ff, map_in;
   logic [15:0] mlen_ff, mlen_in;
   logic [7:0]  mbits_ff, mbits_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic        d32_ff, d32_in;
   logic        topdown_ff, topdown_in;
   logic [21:0] skip_ff, skip_in;
   logic [15:0] x_ff, x_in;
   logic [15:0] y_ff, y_in;
   logic [7:0]  pkt_ff, pkt_in;
   logic        run_ff, run_in;
   logic [1:0]  pbi_ff, pbi_in;
   logic [31:0] col_ff, col_in;
   logic [31:0] span_col_ff, span_col_in;
   logic        perr_ff, perr_in;
   logic [1:0]  ecode_ff, ecode_in;
   logic        phdr_ff, phdr_in;
   logic        pdone_ff, pdone_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [1:0]  code_ff, code_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] column_ff, column_in;
   logic [7:0]  len_ff, len_in;
   logic [31:0] ocol_ff, ocol_in;
   logic        last_ff, last_in;

   logic [15:0] avail;
   logic [15:0] cnt16;
   logic [15:0] n16;
   logic [16:0] x_sum;
   logic        row_end;
   logic [16:0] y_inc;
   logic        fin;
   logic [23:0] map_prod;
   logic [21:0] map_bytes;
   logic [21:0] skip_total;
   logic [31:0] asm_col;
   logic [7:0]  b;
   phase_type   eph;
   logic [4:0]  eidx;
   logic        last_lane;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         perr_ff  <= 1'b0;
         phdr_ff  <= 1'b0;
         pdone_ff <= 1'b0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         perr_ff  <= perr_in;
         phdr_ff  <= phdr_in;
         pdone_ff <= pdone_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hidx_ff     <= hidx_in;
      id_len_ff   <= id_len_in;
      is_rle_ff   <= is_rle_in;
      map_ff      <= map_in;
      mlen_ff     <= mlen_in;
      mbits_ff    <= mbits_in;
      width_ff    <= width_in;
      height_ff   <= height_in;
      d32_ff      <= d32_in;
      topdown_ff  <= topdown_in;
      skip_ff     <= skip_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      pkt_ff      <= pkt_in;
      run_ff      <= run_in;
      pbi_ff      <= pbi_in;
      col_ff      <= col_in;
      span_col_ff <= span_col_in;
      ecode_ff    <= ecode_in;
      kind_ff     <= kind_in;
      code_ff     <= code_in;
      row_ff      <= row_in;
      column_ff   <= column_in;
      len_ff      <= len_in;
      ocol_ff     <= ocol_in;
      last_ff     <= last_in;
   end

   // span arithmetic
   always_comb begin
      avail   = width_ff - x_ff;
      cnt16   = {8'd0, cnt_ff};
      n16     = (cnt16 < avail) ? cnt16 : avail;
      x_sum   = {1'b0, x_ff} + {1'b0, n16};
      row_end = (x_sum >= {1'b0, width_ff});
      y_inc   = {1'b0, y_ff} + 17'd1;
      fin     = row_end && (y_inc >= {1'b0, height_ff});
   end

   always_comb begin
      map_prod   = mlen_ff * {8'd0, mbits_ff};
      map_bytes  = 22'((25'(map_prod) + 25'd7) >> 3);
      skip_total = {14'd0, id_len_ff} + ((map_ff && mlen_ff != 16'd0) ? map_bytes : 22'd0);
      b          = req_data_byte;
      asm_col    = col_ff;
      case (pbi_ff)
         2'd0:    asm_col[7:0]   = b;
         2'd1:    asm_col[15:8]  = b;
         2'd2:    asm_col[23:16] = b;
         default: asm_col[31:24] = b;
      endcase
      last_lane = d32_ff ? (pbi_ff == 2'd3) : (pbi_ff == 2'd2);
      eph       = req_first_byte ? PH_HEADER : phase_ff;
      eidx      = req_first_byte ? 5'd0 : hidx_ff;
   end

   always_comb begin
      phase_in    = phase_ff;
      hidx_in     = hidx_ff;
      id_len_in   = id_len_ff;
      is_rle_in   = is_rle_ff;
      map_in      = map_ff;
      mlen_in     = mlen_ff;
      mbits_in    = mbits_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      d32_in      = d32_ff;
      topdown_in  = topdown_ff;
      skip_in     = skip_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      pkt_in      = pkt_ff;
      run_in      = run_ff;
      pbi_in      = pbi_ff;
      col_in      = col_ff;
      span_col_in = span_col_ff;
      perr_in     = perr_ff;
      ecode_in    = ecode_ff;
      phdr_in     = phdr_ff;
      pdone_in    = pdone_ff;
      cnt_in      = cnt_ff;
      valid_in    = valid_ff & ~rsp_ready;
      kind_in     = kind_ff;
      code_in     = code_ff;
      row_in      = row_ff;
      column_in   = column_ff;
      len_in      = len_ff;
      ocol_in     = ocol_ff;
      last_in     = last_ff;
      sts.last_now = 1'b1;
      sts.out_free = ~valid_ff | rsp_ready;
      sts.pending  = perr_ff | phdr_ff | pdone_ff | (cnt_ff != 8'd0);

      // byte parse
      if (eph != PH_IDLE) begin
         if (req_first_byte) hidx_in = 5'd0;
         if (req_end_of_stream) begin
            perr_in  = 1'b1;
            ecode_in = ERR_TRUNC;
            phase_in = PH_IDLE;
         end else begin
            case (eph)
               PH_HEADER: begin
                  phase_in = PH_HEADER;
                  if (eidx < HB_DESC) hidx_in = eidx + 5'd1;
                  case (eidx)
                     HB_ID_LEN:  id_len_in = b;
                     HB_MAP:     map_in = (b != 8'd0);
                     HB_TYPE: begin
                        is_rle_in = (b == TYPE_RLE);
                        if (b != TYPE_RAW && b != TYPE_RLE) begin
                           perr_in  = 1'b1;
                           ecode_in = ERR_TYPE;
                           phase_in = PH_IDLE;
                        end
                     end
                     HB_MLEN_LO: mlen_in[7:0] = b;
                     HB_MLEN_HI: mlen_in[15:8] = b;
                     HB_MBITS:   mbits_in = b;
                     HB_W_LO:    width_in[7:0] = b;
                     HB_W_HI:    width_in[15:8] = b;
                     HB_H_LO:    height_in[7:0] = b;
                     HB_H_HI:    height_in[15:8] = b;
                     HB_DEPTH: begin
                        d32_in = (b == DEPTH_32);
                        if (b != DEPTH_24 && b != DEPTH_32) begin
                           perr_in  = 1'b1;
                           ecode_in = ERR_DEPTH;
                           phase_in = PH_IDLE;
                        end
                     end
                     HB_DESC: begin
                        topdown_in = b[5];
                        x_in = '0;
                        y_in = '0;
                        if (width_ff == 16'd0 || height_ff == 16'd0) begin
                           phdr_in  = 1'b1;
                           pdone_in = 1'b1;
                           phase_in = PH_IDLE;
                        end else if (is_rle_ff && width_ff < MIN_RUN_WIDTH) begin
                           perr_in  = 1'b1;
                           ecode_in = ERR_NARROW;
                           phase_in = PH_IDLE;
                        end else begin
                           phdr_in = 1'b1;
                           skip_in = skip_total;
                           pbi_in  = '0;
                           col_in  = '0;
                           if (skip_total != 22'd0) phase_in = PH_SKIP;
                           else phase_in = is_rle_ff ? PH_PACKET : PH_PIXEL;
                        end
                     end
                     default: ;
                  endcase
               end
               PH_SKIP: begin
                  skip_in = skip_ff - 22'd1;
                  if (skip_ff == 22'd1) begin
                     phase_in = is_rle_ff ? PH_PACKET : PH_PIXEL;
                     pbi_in   = '0;
                     col_in   = '0;
                  end
               end
               PH_PACKET: begin
                  pkt_in   = {1'b0, b[6:0]} + 8'd1;
                  run_in   = b[7];
                  pbi_in   = '0;
                  col_in   = '0;
                  phase_in = PH_PIXEL;
               end
               PH_PIXEL: begin
                  if (!last_lane) begin
                     pbi_in = pbi_ff + 2'd1;
                     col_in = asm_col;
                  end else begin
                     pbi_in      = '0;
                     col_in      = '0;
                     span_col_in = asm_col;
                     if (!is_rle_ff) begin
                        cnt_in = 8'd1;
                     end else if (run_ff) begin
                        phase_in = PH_PACKET;
                        cnt_in   = pkt_ff;
                        pkt_in   = '0;
                     end else begin
                        pkt_in = pkt_ff - 8'd1;
                        if (pkt_ff == 8'd1) phase_in = PH_PACKET;
                        cnt_in = 8'd1;
                     end
                  end
               end
               default: ;
            endcase
         end
      end

      sts.will_emit = perr_in | phdr_in | (cnt_in != 8'd0);
      if (!cmd.take_byte) begin
         phase_in    = phase_ff;
         hidx_in     = hidx_ff;
         id_len_in   = id_len_ff;
         is_rle_in   = is_rle_ff;
         map_in      = map_ff;
         mlen_in     = mlen_ff;
         mbits_in    = mbits_ff;
         width_in    = width_ff;
         height_in   = height_ff;
         d32_in      = d32_ff;
         topdown_in  = topdown_ff;
         skip_in     = skip_ff;
         x_in        = x_ff;
         y_in        = y_ff;
         pkt_in      = pkt_ff;
         run_in      = run_ff;
         pbi_in      = pbi_ff;
         col_in      = col_ff;
         span_col_in = span_col_ff;
         perr_in     = perr_ff;
         ecode_in    = ecode_ff;
         phdr_in     = phdr_ff;
         pdone_in    = pdone_ff;
         cnt_in      = cnt_ff;
      end

      // result selection
      if (perr_ff) begin
         sts.last_now = 1'b1;
      end else if (phdr_ff) begin
         sts.last_now = ~pdone_ff;
      end else if (cnt_ff != 8'd0) begin
         sts.last_now = ~fin && (cnt_ff == n16[7:0]);
      end else begin
         sts.last_now = 1'b1;
      end

      if (cmd.emit_step) begin
         valid_in  = 1'b1;
         code_in   = ERR_TYPE;
         row_in    = '0;
         column_in = '0;
         len_in    = '0;
         ocol_in   = '0;
         last_in   = sts.last_now;
         if (perr_ff) begin
            kind_in = KIND_ERROR;
            code_in = ecode_ff;
            perr_in = 1'b0;
         end else if (phdr_ff) begin
            kind_in   = KIND_HEADER;
            row_in    = height_ff;
            column_in = width_ff;
            phdr_in   = 1'b0;
         end else if (cnt_ff != 8'd0) begin
            kind_in   = KIND_SPAN;
            row_in    = topdown_ff ? y_ff : (height_ff - 16'd1 - y_ff);
            column_in = x_ff;
            len_in    = n16[7:0];
            ocol_in   = {d32_ff ? span_col_ff[31:24] : 8'hFF, span_col_ff[23:0]};
            x_in      = row_end ? 16'd0 : x_sum[15:0];
            y_in      = row_end ? y_inc[15:0] : y_ff;
            cnt_in    = fin ? 8'd0 : (cnt_ff - n16[7:0]);
            if (fin) begin
               pdone_in = 1'b1;
               phase_in = PH_IDLE;
            end
         end else begin
            kind_in  = KIND_DONE;
            pdone_in = 1'b0;
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_fault       = code_ff;
   assign rsp_row         = row_ff;
   assign rsp_column      = column_ff;
   assign rsp_span_length = len_ff;
   assign rsp_red         = ocol_ff[23:16];
   assign rsp_green       = ocol_ff[15:8];
   assign rsp_blue        = ocol_ff[7:0];
   assign rsp_alpha       = ocol_ff[31:24];
   assign rsp_last_result = last_ff;
endmodule
`default_nettype wire

// ===== sv/tga_rle_image_decoder_top.sv =====
// one byte per cycle while no result is produced; a byte that produces
// results holds off the next byte until all its results have left, each
// span or status word leaving in turn through a single output register
// a byte's first result is registered in the emit state after its transfer
// a run of up to 128 pixels is emitted as one span per row it touches
// synchronous active-high reset returns the parser to idle, awaiting a first byte
`default_nettype none
`include "assert_macros.svh"
module tga_rle_image_decoder_top import tga_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_first_byte,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_end_of_stream,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_fault,
   output logic [15:0] rsp_row,
   output logic [15:0] rsp_column,
   output logic [7:0]  rsp_span_length,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic        rsp_last_result
);
   cmd_type cmd;
   sts_type sts;
   logic    final_kind;

   tga_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tga_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_first_byte    (req_first_byte),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_fault         (rsp_fault),
      .rsp_row           (rsp_row),
      .rsp_column        (rsp_column),
      .rsp_span_length   (rsp_span_length),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha),
      .rsp_last_result   (rsp_last_result)
   );

   assign final_kind = (rsp_kind == KIND_DONE) || (rsp_kind == KIND_ERROR);

   // no new byte while results of the last one remain
   `ASSERT_IMPLIES(a_no_take_pending, clock, reset, req_ready, !sts.pending)
   `ASSERT_IMPLIES(a_final_kinds, clock, reset, rsp_valid && final_kind, rsp_last_result)
   `ASSERT_IMPLIES(a_span_len, clock, reset, rsp_valid && rsp_kind == KIND_SPAN, rsp_span_length != 8'd0)
endmodule
`default_nettype wire
